// ===== hw/rtl/tx_admission_congestion_monitor_unit_macros.svh =====
// assertion macros for the transmit admission monitor datapath
`ifndef TX_ADMISSION_CONGESTION_MONITOR_UNIT_MACROS_SVH
`define TX_ADMISSION_CONGESTION_MONITOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every edge out of reset
`define TXACM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TXACM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TXACM_ASSERT_SAME(lbl, ante, cons, msg)
`define TXACM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/txacm_pkg.sv =====
// package: types, codes and constants of the transmit admission monitor
`timescale 1ns / 1ps

package txacm_pkg;

    localparam int TIME_BITS = 32;
    typedef logic [TIME_BITS-1:0] time_t;

    // request modes
    localparam logic [1:0] MODE_SEND  = 2'd0;
    localparam logic [1:0] MODE_POLL  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_SENT     = 3'd0;
    localparam logic [2:0] ST_EMPTY_OK = 3'd1;
    localparam logic [2:0] ST_NOT_OPEN = 3'd2;
    localparam logic [2:0] ST_DATA_SHED = 3'd3;
    localparam logic [2:0] ST_BLOB_HELD = 3'd4;
    localparam logic [2:0] ST_CTRL_REF = 3'd5;
    localparam logic [2:0] ST_CLOSED   = 3'd6;

    // congestion levels
    localparam logic [1:0] LVL_CLEAR     = 2'd0;
    localparam logic [1:0] LVL_CONGESTED = 2'd1;
    localparam logic [1:0] LVL_SEVERE    = 2'd2;

    // policy codes
    localparam logic [1:0] POL_DROP_ONLY   = 2'd1;
    localparam logic [1:0] POL_CLOSE_ALWAYS = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_TX_POLICY      = 3'd0;
    localparam logic [2:0] CFG_DATA_HIGH_WATER = 3'd1;
    localparam logic [2:0] CFG_BLOB_IN_FLIGHT = 3'd2;
    localparam logic [2:0] CFG_QUEUE_CAPACITY = 3'd3;
    localparam logic [2:0] CFG_CTRL_STALL     = 3'd4;
    localparam logic [2:0] CFG_CONG_SUSTAIN   = 3'd5;
    localparam logic [2:0] CFG_RECOV_SUSTAIN  = 3'd6;
    localparam logic [2:0] CFG_TYPE_CODES     = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // register reset values
    localparam logic [1:0]  RST_TX_POLICY       = 2'd0;
    localparam logic [7:0]  RST_DATA_HIGH_WATER = 8'd16;
    localparam logic [7:0]  RST_BLOB_IN_FLIGHT  = 8'd4;
    localparam logic [7:0]  RST_QUEUE_CAPACITY  = 8'd32;
    localparam logic [15:0] RST_CTRL_STALL      = 16'd5000;
    localparam logic [15:0] RST_CONG_SUSTAIN    = 16'd1000;
    localparam logic [15:0] RST_RECOV_SUSTAIN   = 16'd3000;
    localparam logic [23:0] RST_TYPE_CODES      = 24'd197121;

    // percent fill: pct > 50 <=> q*100 >= 51*cap, pct < 20 <=> q*100 < 20*cap
    localparam int PCT_SCALE  = 100;
    localparam int PCT_HI_MUL = 51;
    localparam int PCT_LO_MUL = 20;
    localparam int PCT_W      = 15;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  frame_type;
        logic        frame_empty;
        logic        link_open;
        logic        client_present;
        logic        queue_found;
        logic [7:0]  queue_len;
        logic        send_accepted;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic        send_frame;
        logic        close_session;
        logic [2:0]  status;
        logic [1:0]  congestion_level;
        logic [31:0] data_drop_count;
        logic [31:0] blob_hold_count;
        logic [31:0] ctrl_fail_count;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic update;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_stall;
    } sts_t;

endpackage

// ===== hw/rtl/txacm_if.sv =====
// channel interfaces: request, response and configuration write
`timescale 1ns / 1ps

interface txacm_req_if;
    import txacm_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface txacm_rsp_if;
    import txacm_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface txacm_cfg_if;
    import txacm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tx_admission_congestion_monitor_unit.sv =====
// top level of the transmit admission and congestion monitor
`timescale 1ns / 1ps

// transmit admission and congestion monitor
// req channel: one request per send attempt, congestion poll or new-client clear
//   (mode selects which); rsp channel: exactly one response per request, in order
// cfg channel: register writes by index, always ready; write only while idle
// a request is taken in the idle state, evaluated in the next cycle (type sort,
//   gate compares, percent fill against capacity, timer deltas) and committed in
//   the update state once the response register is free, when session state and
//   the response register update together
// a new request is taken only once the previous one has gone through the
//   capture/evaluate/commit sequence of the controller
// the response register decouples the sides: a new request is taken while the
//   previous response still waits; if rsp stalls, the commit waits until the
//   response register drains, then req is blocked until that commit is done
// reset: registers return to their reset values, timers unarmed, level clear,
//   counters zero, no response pending

module tx_admission_congestion_monitor_unit
    import txacm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    txacm_req_if.sink   req,
    txacm_rsp_if.source rsp,
    txacm_cfg_if.sink   cfg
);

    // controller to datapath commands and status back
    cmd_t cmd;
    sts_t sts;

    // config writes are always accepted
    assign cfg.ready = 1'b1;

    txacm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    txacm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (req.data),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .out_data  (rsp.data)
    );

endmodule

// ===== hw/rtl/txacm_ctrl.sv =====
// controller: sequences capture, evaluate and commit for each request
`timescale 1ns / 1ps

module txacm_ctrl
    import txacm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                // commit only once the result register is free
                if (!sts.out_stall)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/txacm_dp.sv =====
// datapath: config registers, session state, evaluation flags and result register
`timescale 1ns / 1ps
`include "tx_admission_congestion_monitor_unit_macros.svh"

module txacm_dp
    import txacm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  in_item_t               in_data,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output out_item_t              out_data
);

    // configuration
    logic [1:0]  tx_policy_reg;
    logic [7:0]  data_high_water_reg;
    logic [7:0]  blob_in_flight_reg;
    logic [7:0]  queue_capacity_reg;
    logic [15:0] ctrl_stall_reg;
    logic [15:0] cong_sustain_reg;
    logic [15:0] recov_sustain_reg;
    logic [23:0] type_codes_reg;

    // session state
    time_t       stall_since_reg, stall_since_next;
    time_t       above_since_reg, above_since_next;
    time_t       below_since_reg, below_since_next;
    logic [1:0]  level_reg, level_next;
    logic [31:0] data_drops_reg, data_drops_next;
    logic [31:0] blob_holds_reg, blob_holds_next;
    logic [31:0] ctrl_fails_reg, ctrl_fails_next;

    // captured request and evaluation flags
    in_item_t    in_reg;
    logic        drop_reg, blob_reg, shed_reg, hold_reg, expired_reg;
    logic        hi_reg, lo_reg, above_hit_reg, below_hit_reg;

    out_item_t   out_data_reg, out_data_next;
    logic        out_valid_reg;

    // evaluation logic
    time_t             now_t;
    logic              drop_c, blob_c, gate_c;
    logic [7:0]        q_c, cap_c;
    logic [PCT_W-1:0]  q_scaled, hi_bound, lo_bound;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_policy_reg       <= RST_TX_POLICY;
            data_high_water_reg <= RST_DATA_HIGH_WATER;
            blob_in_flight_reg  <= RST_BLOB_IN_FLIGHT;
            queue_capacity_reg  <= RST_QUEUE_CAPACITY;
            ctrl_stall_reg      <= RST_CTRL_STALL;
            cong_sustain_reg    <= RST_CONG_SUSTAIN;
            recov_sustain_reg   <= RST_RECOV_SUSTAIN;
            type_codes_reg      <= RST_TYPE_CODES;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TX_POLICY:       tx_policy_reg       <= cfg_data[1:0];
                CFG_DATA_HIGH_WATER: data_high_water_reg <= cfg_data[7:0];
                CFG_BLOB_IN_FLIGHT:  blob_in_flight_reg  <= cfg_data[7:0];
                CFG_QUEUE_CAPACITY:  queue_capacity_reg  <= cfg_data[7:0];
                CFG_CTRL_STALL:      ctrl_stall_reg      <= cfg_data[15:0];
                CFG_CONG_SUSTAIN:    cong_sustain_reg    <= cfg_data[15:0];
                CFG_RECOV_SUSTAIN:   recov_sustain_reg   <= cfg_data[15:0];
                CFG_TYPE_CODES:      type_codes_reg      <= cfg_data;
                default:             type_codes_reg      <= type_codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
    end

    // classification, gates and timer compares
    assign now_t  = time_t'(in_reg.now_ms);
    assign drop_c = (in_reg.frame_type == type_codes_reg[7:0]) ||
                    (in_reg.frame_type == type_codes_reg[15:8]);
    assign blob_c = !drop_c && (in_reg.frame_type == type_codes_reg[23:16]);
    assign gate_c = (tx_policy_reg != POL_CLOSE_ALWAYS) && in_reg.queue_found;

    assign q_c      = (in_reg.client_present && in_reg.queue_found) ? in_reg.queue_len : 8'd0;
    assign cap_c    = (queue_capacity_reg == 8'd0) ? 8'd1 : queue_capacity_reg;
    assign q_scaled = PCT_W'(q_c) * PCT_W'(PCT_SCALE);
    assign hi_bound = PCT_W'(cap_c) * PCT_W'(PCT_HI_MUL);
    assign lo_bound = PCT_W'(cap_c) * PCT_W'(PCT_LO_MUL);

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            drop_reg    <= drop_c;
            blob_reg    <= blob_c;
            shed_reg    <= gate_c && drop_c && (in_reg.queue_len >= data_high_water_reg);
            hold_reg    <= gate_c && blob_c && (in_reg.queue_len >= blob_in_flight_reg);
            expired_reg <= (now_t - stall_since_reg) >= time_t'(ctrl_stall_reg);
            hi_reg      <= q_scaled >= hi_bound;
            lo_reg      <= q_scaled < lo_bound;
            // an unarmed timer arms at now, so the elapsed time is zero
            above_hit_reg <= (above_since_reg == '0) ? (cong_sustain_reg == 16'd0)
                           : ((now_t - above_since_reg) >= time_t'(cong_sustain_reg));
            below_hit_reg <= (below_since_reg == '0) ? (recov_sustain_reg == 16'd0)
                           : ((now_t - below_since_reg) >= time_t'(recov_sustain_reg));
        end
    end

    // commit logic
    always_comb
    begin
        stall_since_next = stall_since_reg;
        above_since_next = above_since_reg;
        below_since_next = below_since_reg;
        level_next       = level_reg;
        data_drops_next  = data_drops_reg;
        blob_holds_next  = blob_holds_reg;
        ctrl_fails_next  = ctrl_fails_reg;
        out_data_next    = '0;

        unique case (in_reg.mode)
            MODE_SEND:
            begin
                priority if (!in_reg.link_open)
                begin
                    out_data_next.status = ST_NOT_OPEN;
                end
                else if (in_reg.frame_empty)
                begin
                    out_data_next.accepted = 1'b1;
                    out_data_next.status   = ST_EMPTY_OK;
                end
                else if (!in_reg.client_present)
                begin
                    out_data_next.status = ST_NOT_OPEN;
                end
                else if (shed_reg)
                begin
                    data_drops_next      = data_drops_reg + 32'd1;
                    out_data_next.status = ST_DATA_SHED;
                end
                else if (hold_reg)
                begin
                    blob_holds_next      = blob_holds_reg + 32'd1;
                    out_data_next.status = ST_BLOB_HELD;
                end
                else
                begin
                    out_data_next.send_frame = 1'b1;
                    priority if (in_reg.send_accepted)
                    begin
                        if (!drop_reg && !blob_reg)
                        begin
                            stall_since_next = '0;
                        end
                        out_data_next.accepted = 1'b1;
                        out_data_next.status   = ST_SENT;
                    end
                    else if (drop_reg)
                    begin
                        data_drops_next      = data_drops_reg + 32'd1;
                        out_data_next.status = ST_DATA_SHED;
                    end
                    else if (blob_reg)
                    begin
                        blob_holds_next      = blob_holds_reg + 32'd1;
                        out_data_next.status = ST_BLOB_HELD;
                    end
                    else
                    begin
                        ctrl_fails_next = ctrl_fails_reg + 32'd1;
                        priority if (stall_since_reg == '0)
                        begin
                            stall_since_next     = now_t;
                            out_data_next.status = ST_CTRL_REF;
                        end
                        else if (tx_policy_reg == POL_DROP_ONLY || !expired_reg)
                        begin
                            out_data_next.status = ST_CTRL_REF;
                        end
                        else
                        begin
                            stall_since_next            = '0;
                            out_data_next.close_session = 1'b1;
                            out_data_next.status        = ST_CLOSED;
                        end
                    end
                end
            end
            MODE_POLL:
            begin
                priority if (stall_since_reg != '0)
                begin
                    above_since_next = '0;
                    below_since_next = '0;
                    level_next       = LVL_SEVERE;
                end
                else if (hi_reg)
                begin
                    below_since_next = '0;
                    if (above_since_reg == '0)
                    begin
                        above_since_next = now_t;
                    end
                    if (above_hit_reg)
                    begin
                        level_next = LVL_CONGESTED;
                    end
                end
                else if (lo_reg)
                begin
                    above_since_next = '0;
                    if (below_since_reg == '0)
                    begin
                        below_since_next = now_t;
                    end
                    if (below_hit_reg)
                    begin
                        level_next = LVL_CLEAR;
                    end
                end
                else
                begin
                    above_since_next = '0;
                    below_since_next = '0;
                end
            end
            MODE_CLEAR:
            begin
                stall_since_next = '0;
                above_since_next = '0;
                below_since_next = '0;
                level_next       = LVL_CLEAR;
                data_drops_next  = '0;
                blob_holds_next  = '0;
                ctrl_fails_next  = '0;
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase

        out_data_next.congestion_level = level_next;
        out_data_next.data_drop_count  = data_drops_next;
        out_data_next.blob_hold_count  = blob_holds_next;
        out_data_next.ctrl_fail_count  = ctrl_fails_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_since_reg <= '0;
            above_since_reg <= '0;
            below_since_reg <= '0;
            level_reg       <= LVL_CLEAR;
            data_drops_reg  <= '0;
            blob_holds_reg  <= '0;
            ctrl_fails_reg  <= '0;
        end
        else if (cmd.update)
        begin
            stall_since_reg <= stall_since_next;
            above_since_reg <= above_since_next;
            below_since_reg <= below_since_next;
            level_reg       <= level_next;
            data_drops_reg  <= data_drops_next;
            blob_holds_reg  <= blob_holds_next;
            ctrl_fails_reg  <= ctrl_fails_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign sts.out_stall = out_valid_reg && !out_ready;

    `TXACM_ASSERT_SAME(a_no_overwrite, cmd.update, !(out_valid_reg && !out_ready), "result overwritten while stalled")
    `TXACM_ASSERT_NEXT(a_commit_shows, cmd.update, out_valid_reg && level_reg == out_data_reg.congestion_level, "committed result not presented")
    `TXACM_ASSERT_SAME(a_close_status, out_valid_reg, out_data_reg.close_session == (out_data_reg.status == ST_CLOSED), "close flag and status disagree")

endmodule

// ===== sim/tb_tx_admission_congestion_monitor_unit.sv =====
// testbench for the transmit admission and congestion monitor: directed and random requests
`timescale 1ns / 1ps

module tb_tx_admission_congestion_monitor_unit;
    import txacm_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic [1:0] POL_NORMAL   = 2'd0;
    localparam logic [1:0] POL_RESERVED = 2'd3;

    // percent thresholds of the congestion hysteresis
    localparam int unsigned PCT_CONGESTED = 50;
    localparam int unsigned PCT_RECOVERED = 20;

    // frame types under the reset type codes
    localparam logic [7:0] T_STATE  = RST_TYPE_CODES[7:0];
    localparam logic [7:0] T_STREAM = RST_TYPE_CODES[15:8];
    localparam logic [7:0] T_BLOB   = RST_TYPE_CODES[23:16];
    localparam logic [7:0] T_CTRL   = 8'h80;

    // quiet cycles waited after the last expected response, for margin
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT_NS = 5_000_000;

    typedef struct packed {
        logic [1:0]  policy;
        logic [7:0]  high_water;
        logic [7:0]  blob_budget;
        logic [7:0]  capacity;
        logic [15:0] stall_limit;
        logic [15:0] cong_sustain;
        logic [15:0] recov_sustain;
        logic [23:0] type_codes;
    } admission_cfg_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    txacm_req_if req ();
    txacm_rsp_if rsp ();
    txacm_cfg_if cfg ();

    tx_admission_congestion_monitor_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #6 clk = ~clk;

    // register shadow, starts at the reset values
    admission_cfg_t cfg_now = '{RST_TX_POLICY, RST_DATA_HIGH_WATER, RST_BLOB_IN_FLIGHT,
                                RST_QUEUE_CAPACITY, RST_CTRL_STALL, RST_CONG_SUSTAIN,
                                RST_RECOV_SUSTAIN, RST_TYPE_CODES};

    // session state of the predictor; zero timestamp means the timer is not armed
    time_t       stall_since = '0;
    time_t       above_since = '0;
    time_t       below_since = '0;
    logic [1:0]  level       = LVL_CLEAR;
    logic [31:0] data_drops  = '0;
    logic [31:0] blob_holds  = '0;
    logic [31:0] ctrl_fails  = '0;

    out_item_t   admission_results_due[$];
    int unsigned mismatches = 0;
    bit          idle_en = 1'b1;
    time_t       clock_ms = '0;

    // ------------------------------------------------------------------
    // predictor: one response per request, state advanced in request order
    // ------------------------------------------------------------------
    function automatic out_item_t admit_and_monitor(input in_item_t item);
        out_item_t   r;
        time_t       now;
        logic        is_data;
        logic        is_blob;
        logic        gates_on;
        int unsigned fill;
        int unsigned cap;
        int unsigned pct;
        r = '0;
        now = item.now_ms;
        // data sorting wins when the type codes coincide
        is_data = item.frame_type == cfg_now.type_codes[7:0] ||
                  item.frame_type == cfg_now.type_codes[15:8];
        is_blob = !is_data && item.frame_type == cfg_now.type_codes[23:16];
        // close-always policy disables early shed and the blob gate
        gates_on = cfg_now.policy != POL_CLOSE_ALWAYS;
        case (item.mode)
            MODE_SEND: begin
                if (!item.link_open) begin
                    r.status = ST_NOT_OPEN;
                end else if (item.frame_empty) begin
                    r.accepted = 1'b1;
                    r.status = ST_EMPTY_OK;
                end else if (!item.client_present) begin
                    r.status = ST_NOT_OPEN;
                end else if (gates_on && is_data && item.queue_found &&
                             item.queue_len >= cfg_now.high_water) begin
                    data_drops++;
                    r.status = ST_DATA_SHED;
                end else if (gates_on && is_blob && item.queue_found &&
                             item.queue_len >= cfg_now.blob_budget) begin
                    blob_holds++;
                    r.status = ST_BLOB_HELD;
                end else begin
                    // frame goes downstream from here on
                    r.send_frame = 1'b1;
                    if (item.send_accepted) begin
                        // a control frame that gets through ends any stall
                        if (!is_data && !is_blob)
                            stall_since = '0;
                        r.accepted = 1'b1;
                        r.status = ST_SENT;
                    end else if (is_data) begin
                        data_drops++;
                        r.status = ST_DATA_SHED;
                    end else if (is_blob) begin
                        blob_holds++;
                        r.status = ST_BLOB_HELD;
                    end else begin
                        ctrl_fails++;
                        if (stall_since == '0) begin
                            // arming at time zero leaves the timer unarmed
                            stall_since = now;
                            r.status = ST_CTRL_REF;
                        end else if (cfg_now.policy == POL_DROP_ONLY) begin
                            r.status = ST_CTRL_REF;
                        end else if (time_t'(now - stall_since) <
                                     time_t'(cfg_now.stall_limit)) begin
                            r.status = ST_CTRL_REF;
                        end else begin
                            stall_since = '0;
                            r.close_session = 1'b1;
                            r.status = ST_CLOSED;
                        end
                    end
                end
            end
            MODE_POLL: begin
                if (stall_since != '0) begin
                    above_since = '0;
                    below_since = '0;
                    level = LVL_SEVERE;
                end else begin
                    // no client or no queue reads as an empty queue
                    fill = (item.client_present && item.queue_found) ? item.queue_len : 0;
                    cap = (cfg_now.capacity == '0) ? 1 : cfg_now.capacity;
                    pct = fill * PCT_SCALE / cap;
                    if (pct > PCT_CONGESTED) begin
                        below_since = '0;
                        if (above_since == '0)
                            above_since = now;
                        if (time_t'(now - above_since) >= time_t'(cfg_now.cong_sustain))
                            level = LVL_CONGESTED;
                    end else if (pct < PCT_RECOVERED) begin
                        above_since = '0;
                        if (below_since == '0)
                            below_since = now;
                        if (time_t'(now - below_since) >= time_t'(cfg_now.recov_sustain))
                            level = LVL_CLEAR;
                    end else begin
                        above_since = '0;
                        below_since = '0;
                    end
                end
            end
            MODE_CLEAR: begin
                stall_since = '0;
                above_since = '0;
                below_since = '0;
                level = LVL_CLEAR;
                data_drops = '0;
                blob_holds = '0;
                ctrl_fails = '0;
            end
            default: ;  // unused mode leaves everything as it is
        endcase
        r.congestion_level = level;
        r.data_drop_count = data_drops;
        r.blob_hold_count = blob_holds;
        r.ctrl_fail_count = ctrl_fails;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    function automatic in_item_t make_request(input logic [1:0] mode, input logic [7:0] ftype,
                                              input logic empty, input logic open,
                                              input logic client, input logic found,
                                              input logic [7:0] qlen, input logic taken,
                                              input time_t stamp);
        in_item_t item;
        item.mode = mode;
        item.frame_type = ftype;
        item.frame_empty = empty;
        item.link_open = open;
        item.client_present = client;
        item.queue_found = found;
        item.queue_len = qlen;
        item.send_accepted = taken;
        item.now_ms = stamp;
        return item;
    endfunction

    // valid stays high from one request to the next unless an idle burst comes first
    task automatic send_request(input in_item_t item);
        if (idle_en && $urandom_range(0, 2) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= item;
        do @(posedge clk); while (!req.ready);
        admission_results_due.push_back(admit_and_monitor(item));
    endtask

    // mostly small time steps so timers expire now and then, rare big jumps and zero
    function automatic time_t next_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            clock_ms += $urandom_range(0, 40);
        else if (pick < 95)
            clock_ms += $urandom_range(0, 3000);
        else if (pick < 98)
            clock_ms += $urandom();
        else
            clock_ms = '0;
        return clock_ms;
    endfunction

    function automatic in_item_t random_request();
        in_item_t    item;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            item.mode = MODE_SEND;
        else if (pick < 94)
            item.mode = MODE_POLL;
        else if (pick < 97)
            item.mode = MODE_CLEAR;
        else
            item.mode = MODE_UNUSED;
        // lean toward the configured type codes
        case ($urandom_range(0, 9))
            0, 1:    item.frame_type = cfg_now.type_codes[7:0];
            2:       item.frame_type = cfg_now.type_codes[15:8];
            3, 4:    item.frame_type = cfg_now.type_codes[23:16];
            default: item.frame_type = 8'($urandom_range(0, 255));
        endcase
        item.frame_empty = $urandom_range(0, 15) == 0;
        item.link_open = $urandom_range(0, 15) != 0;
        item.client_present = $urandom_range(0, 15) != 0;
        item.queue_found = $urandom_range(0, 9) != 0;
        // queue length around the gate thresholds and the capacity
        case ($urandom_range(0, 9))
            0, 1, 2: item.queue_len = cfg_now.high_water + 8'($urandom_range(0, 2)) - 8'd1;
            3, 4:    item.queue_len = cfg_now.blob_budget + 8'($urandom_range(0, 2)) - 8'd1;
            5, 6:    item.queue_len = 8'($urandom_range(0, cfg_now.capacity));
            default: item.queue_len = 8'($urandom_range(0, 255));
        endcase
        item.send_accepted = 1'($urandom_range(0, 1));
        item.now_ms = next_stamp();
        return item;
    endfunction

    // control frame that reaches downstream and is refused there
    function automatic in_item_t refused_control();
        in_item_t item;
        item = random_request();
        item.mode = MODE_SEND;
        do
            item.frame_type = 8'($urandom_range(0, 255));
        while (item.frame_type == cfg_now.type_codes[7:0] ||
               item.frame_type == cfg_now.type_codes[15:8] ||
               item.frame_type == cfg_now.type_codes[23:16]);
        item.frame_empty = 1'b0;
        item.link_open = 1'b1;
        item.client_present = 1'b1;
        item.send_accepted = 1'b0;
        return item;
    endfunction

    // ------------------------------------------------------------------
    // configuration: only while nothing is in flight
    // ------------------------------------------------------------------
    task automatic wait_idle();
        req.valid <= 1'b0;
        while (admission_results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            CFG_TX_POLICY:       cfg_now.policy = value[1:0];
            CFG_DATA_HIGH_WATER: cfg_now.high_water = value[7:0];
            CFG_BLOB_IN_FLIGHT:  cfg_now.blob_budget = value[7:0];
            CFG_QUEUE_CAPACITY:  cfg_now.capacity = value[7:0];
            CFG_CTRL_STALL:      cfg_now.stall_limit = value[15:0];
            CFG_CONG_SUSTAIN:    cfg_now.cong_sustain = value[15:0];
            CFG_RECOV_SUSTAIN:   cfg_now.recov_sustain = value[15:0];
            CFG_TYPE_CODES:      cfg_now.type_codes = value[23:0];
            default: ;
        endcase
    endtask

    // every register is rewritten on each change of setting
    task automatic set_config(input admission_cfg_t c);
        wait_idle();
        write_reg(CFG_TX_POLICY, CFG_DATA_W'(c.policy));
        write_reg(CFG_DATA_HIGH_WATER, CFG_DATA_W'(c.high_water));
        write_reg(CFG_BLOB_IN_FLIGHT, CFG_DATA_W'(c.blob_budget));
        write_reg(CFG_QUEUE_CAPACITY, CFG_DATA_W'(c.capacity));
        write_reg(CFG_CTRL_STALL, CFG_DATA_W'(c.stall_limit));
        write_reg(CFG_CONG_SUSTAIN, CFG_DATA_W'(c.cong_sustain));
        write_reg(CFG_RECOV_SUSTAIN, CFG_DATA_W'(c.recov_sustain));
        write_reg(CFG_TYPE_CODES, CFG_DATA_W'(c.type_codes));
        cfg.valid <= 1'b0;
    endtask

    // mostly short limits so stalls close and levels move within a phase
    function automatic admission_cfg_t random_config();
        admission_cfg_t c;
        c.policy = 2'($urandom_range(0, 3));
        c.high_water = 8'($urandom_range(0, 255));
        c.blob_budget = 8'($urandom_range(0, 255));
        c.capacity = 8'($urandom_range(0, 255));
        c.stall_limit = 16'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 300)
                                                        : $urandom_range(0, 65535));
        c.cong_sustain = 16'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 500)
                                                         : $urandom_range(0, 65535));
        c.recov_sustain = 16'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 500)
                                                          : $urandom_range(0, 65535));
        c.type_codes = 24'($urandom_range(0, 24'hFFFFFF));
        // sometimes make type codes coincide
        case ($urandom_range(0, 9))
            0: c.type_codes[15:8] = c.type_codes[7:0];
            1: c.type_codes[23:16] = c.type_codes[7:0];
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // response side: random backpressure and in-order compare
    // ------------------------------------------------------------------
    initial begin : response_backpressure
        rsp.ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 3) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : check_responses
        out_item_t want;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (admission_results_due.size() == 0) begin
                mismatches++;
                $display("%0t: response with none expected, expected none actual %h",
                         $time, rsp.data);
            end else begin
                want = admission_results_due.pop_front();
                compare_field("accepted", 32'(want.accepted), 32'(rsp.data.accepted));
                compare_field("send_frame", 32'(want.send_frame), 32'(rsp.data.send_frame));
                compare_field("close_session", 32'(want.close_session),
                              32'(rsp.data.close_session));
                compare_field("status", 32'(want.status), 32'(rsp.data.status));
                compare_field("congestion_level", 32'(want.congestion_level),
                              32'(rsp.data.congestion_level));
                compare_field("data_drop_count", want.data_drop_count,
                              rsp.data.data_drop_count);
                compare_field("blob_hold_count", want.blob_hold_count,
                              rsp.data.blob_hold_count);
                compare_field("ctrl_fail_count", want.ctrl_fail_count,
                              rsp.data.ctrl_fail_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every status path and the poll hysteresis under reset settings
    task automatic test_send_paths();
        // refusals and the empty-frame pass before the type sort
        send_request(make_request(MODE_SEND, T_CTRL, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 1'b1, 100));
        send_request(make_request(MODE_SEND, T_CTRL, 1'b1, 1'b0, 1'b1, 1'b1, 8'd0, 1'b1, 110));
        send_request(make_request(MODE_SEND, T_CTRL, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 120));
        send_request(make_request(MODE_SEND, T_STATE, 1'b0, 1'b1, 1'b0, 1'b1, 8'd0, 1'b1, 130));
        // data shed at the high-water mark, sent just below it
        send_request(make_request(MODE_SEND, T_STATE, 1'b0, 1'b1, 1'b1, 1'b1, 8'd16, 1'b1, 140));
        send_request(make_request(MODE_SEND, T_STREAM, 1'b0, 1'b1, 1'b1, 1'b1, 8'd15, 1'b1, 150));
        // queue missing: no early shed, refused downstream
        send_request(make_request(MODE_SEND, T_STREAM, 1'b0, 1'b1, 1'b1, 1'b0, 8'd255, 1'b0,
                                  160));
        // blob gate, blob refused downstream, blob with queue missing
        send_request(make_request(MODE_SEND, T_BLOB, 1'b0, 1'b1, 1'b1, 1'b1, 8'd4, 1'b1, 170));
        send_request(make_request(MODE_SEND, T_BLOB, 1'b0, 1'b1, 1'b1, 1'b1, 8'd3, 1'b0, 180));
        send_request(make_request(MODE_SEND, T_BLOB, 1'b0, 1'b1, 1'b1, 1'b0, 8'd200, 1'b1, 190));
        // control refused at time zero stays unarmed
        send_request(make_request(MODE_SEND, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0, 0));
        // arm, severe poll, one ms short of the limit, then at the limit
        send_request(make_request(MODE_SEND, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0, 1000));
        send_request(make_request(MODE_POLL, T_CTRL, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0, 1500));
        send_request(make_request(MODE_SEND, T_CTRL, 1'b0, 1'b1, 1'b1, 1'b1, 8'd1, 1'b0, 5999));
        send_request(make_request(MODE_SEND, T_CTRL, 1'b0, 1'b1, 1'b1, 1'b1, 8'd1, 1'b0, 6000));
        // re-arm, then a control frame that gets through disarms
        send_request(make_request(MODE_SEND, T_CTRL, 1'b0, 1'b1, 1'b1, 1'b1, 8'd2, 1'b0, 7000));
        send_request(make_request(MODE_SEND, T_CTRL, 1'b0, 1'b1, 1'b1, 1'b1, 8'd2, 1'b1, 7100));
        // above half full, sustained, middle band, below a fifth, recovered
        send_request(make_request(MODE_POLL, T_CTRL, 1'b0, 1'b0, 1'b1, 1'b1, 8'd32, 1'b0, 8000));
        send_request(make_request(MODE_POLL, T_CTRL, 1'b0, 1'b0, 1'b1, 1'b1, 8'd17, 1'b0, 9000));
        send_request(make_request(MODE_POLL, T_CTRL, 1'b0, 1'b0, 1'b1, 1'b1, 8'd16, 1'b0, 9200));
        send_request(make_request(MODE_POLL, T_CTRL, 1'b0, 1'b0, 1'b0, 1'b1, 8'd255, 1'b0,
                                  9500));
        send_request(make_request(MODE_POLL, T_CTRL, 1'b0, 1'b0, 1'b1, 1'b1, 8'd6, 1'b0, 12500));
        // unused mode changes nothing, clear wipes the session
        send_request(make_request(MODE_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 1'b1,
                                  32'hFFFF_FFFF));
        send_request(make_request(MODE_CLEAR, T_STATE, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0, 1'b1, 13000));
        // sustain timer armed at the top of the time range, read after the wrap
        send_request(make_request(MODE_POLL, T_CTRL, 1'b0, 1'b0, 1'b1, 1'b1, 8'd255, 1'b0,
                                  32'hFFFF_FFFF));
        send_request(make_request(MODE_POLL, T_CTRL, 1'b0, 1'b0, 1'b1, 1'b1, 8'd255, 1'b0, 999));
    endtask

    // stall sequences under each policy, with short limits
    task automatic test_stall_policies();
        logic [1:0]     policies[4];
        admission_cfg_t c;
        policies = '{POL_DROP_ONLY, POL_CLOSE_ALWAYS, POL_RESERVED, POL_NORMAL};
        foreach (policies[p]) begin
            c = cfg_now;
            c.policy = policies[p];
            c.stall_limit = 16'($urandom_range(0, 120));
            set_config(c);
            repeat (25) begin
                if ($urandom_range(0, 2) != 0)
                    send_request(refused_control());
                else
                    send_request(random_request());
            end
        end
    endtask

    // polls against capacities at the edges, short sustain times
    task automatic test_congestion_hysteresis();
        logic [7:0]     capacities[4];
        admission_cfg_t c;
        in_item_t       item;
        capacities = '{8'd1, 8'd0, 8'd7, 8'd255};
        foreach (capacities[k]) begin
            c = cfg_now;
            c.capacity = capacities[k];
            c.cong_sustain = 16'($urandom_range(0, 200));
            c.recov_sustain = 16'($urandom_range(0, 200));
            set_config(c);
            repeat (30) begin
                item = ($urandom_range(0, 5) == 0) ? refused_control() : random_request();
                if (item.mode != MODE_SEND || $urandom_range(0, 1) == 0) begin
                    item.mode = MODE_POLL;
                    item.queue_len = 8'($urandom_range(0, (c.capacity < 2) ? 2 : c.capacity));
                end
                send_request(item);
            end
        end
    endtask

    // all registers at their minimum, then at their maximum
    task automatic test_config_extremes();
        admission_cfg_t c;
        // all type codes zero: every zero byte is data
        c = '{POL_NORMAL, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 24'd0};
        set_config(c);
        repeat (50) send_request(random_request());
        c = '{POL_RESERVED, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF};
        set_config(c);
        repeat (50) send_request(($urandom_range(0, 3) == 0) ? refused_control()
                                                              : random_request());
    endtask

    // random settings per phase; stall bursts keep the close path busy
    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            set_config(random_config());
            if (phase % 3 == 1)
                clock_ms = $urandom();
            // last phase runs without any idling
            idle_en = (phase < 7) && (phase % 2 == 0 || phase == 3);
            repeat (100) begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(2, 6)) send_request(refused_control());
                else
                    send_request(random_request());
            end
        end
    endtask

    initial begin
        req.valid <= 1'b0;
        req.data <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_send_paths();
        test_stall_policies();
        test_congestion_hysteresis();
        test_config_extremes();
        test_random_traffic();

        // all responses in, then a few quiet cycles for strays
        wait_idle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/txacm_pkg.sv
hw/rtl/txacm_if.sv
hw/rtl/txacm_ctrl.sv
hw/rtl/txacm_dp.sv
hw/rtl/tx_admission_congestion_monitor_unit.sv
sim/tb_tx_admission_congestion_monitor_unit.sv
